/* hdl/sdt_pkg.sv */
// ----------------------------------------------------------------------------
// sdt_pkg
// Shared widths, constants and cell state types for the spontaneous
// deformation tensor unit.
// ----------------------------------------------------------------------------
package sdt_pkg;

  // cell counts
  localparam int CB_CELLS   = 22;
  localparam int SQ_CELLS   = 21;
  localparam int DV_CELLS   = 22;
  localparam int SIN_CELLS  = 4;
  localparam int COS_CELLS  = 5;
  localparam int HRN_STAGES = 3;

  // Q.30 series widths
  localparam int R2_W  = 30;
  localparam int T_W   = 31;
  localparam int U_W   = 30;
  localparam int DIV_W = 7;
  localparam int RCP_W = 32;

  localparam logic [T_W-1:0] ONE_Q30 = 31'h4000_0000;

  localparam logic signed [34:0] HALFPI_Q30 = 35'sd1686629713;
  localparam logic signed [34:0] LIM_Q30    = 35'sd843314856;

  // Taylor divisors and floor(2^32 / d)
  localparam logic [DIV_W-1:0] SIN_DIV [0:SIN_CELLS-1] = '{7'd72, 7'd42, 7'd20, 7'd6};
  localparam logic [RCP_W-1:0] SIN_RCP [0:SIN_CELLS-1] =
    '{32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};
  localparam logic [DIV_W-1:0] COS_DIV [0:COS_CELLS-1] =
    '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
  localparam logic [RCP_W-1:0] COS_RCP [0:COS_CELLS-1] =
    '{32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};

  // cube root cell: radicand shifts out three bits per cell
  typedef struct packed {
    logic [65:0] rad;
    logic [21:0] y;
    logic [43:0] y2;
    logic [47:0] rem;
  } cb_st_t;

  // square root cell: two bits per cell
  typedef struct packed {
    logic [41:0] rad;
    logic [20:0] y;
    logic [22:0] rem;
  } sq_st_t;

  // restoring divide cell: one quotient bit per cell
  typedef struct packed {
    logic [21:0] src;
    logic [20:0] d;
    logic [21:0] q;
    logic [21:0] rem;
  } dv_st_t;

endpackage

/* hdl/sdt_cbrt_cell.sv */
// ----------------------------------------------------------------------------
// sdt_cbrt_cell
// One digit step of the integer cube root; keeps y and y^2 so no multiplier.
// ----------------------------------------------------------------------------
module sdt_cbrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  sdt_pkg::cb_st_t      st_i,
  input  logic [SIDE_W-1:0]    side_i,
  output sdt_pkg::cb_st_t      st_o,
  output logic [SIDE_W-1:0]    side_o
);

  sdt_pkg::cb_st_t   st_r, st_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [21:0]       y_d;
  logic [43:0]       y2_d;
  logic [50:0]       rem_sh, trial, diff;
  logic              take;

  always_comb begin
    y_d    = {st_i.y[20:0], 1'b0};
    y2_d   = {st_i.y2[41:0], 2'b00};
    rem_sh = {st_i.rem, st_i.rad[65:63]};
    // 3*y'^2 + 3*y' + 1
    trial  = {6'b0, y2_d, 1'b0} + {7'b0, y2_d} + {28'b0, y_d, 1'b0}
           + {29'b0, y_d} + 51'd1;
    take   = rem_sh >= trial;
    diff   = rem_sh - trial;
    st_nxt.rad = {st_i.rad[62:0], 3'b000};
    st_nxt.y   = y_d | {21'b0, take};
    st_nxt.y2  = take ? (y2_d + {21'b0, y_d, 1'b0} + 44'd1) : y2_d;
    st_nxt.rem = take ? diff[47:0] : rem_sh[47:0];
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    side_r <= side_i;
  end

  assign st_o   = st_r;
  assign side_o = side_r;

endmodule

/* hdl/sdt_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// sdt_sqrt_cell
// One digit step of the integer square root.
// ----------------------------------------------------------------------------
module sdt_sqrt_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  sdt_pkg::sq_st_t      st_i,
  input  logic [SIDE_W-1:0]    side_i,
  output sdt_pkg::sq_st_t      st_o,
  output logic [SIDE_W-1:0]    side_o
);

  sdt_pkg::sq_st_t   st_r, st_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [24:0]       rem_sh, trial, diff;
  logic              take;

  always_comb begin
    rem_sh     = {st_i.rem, st_i.rad[41:40]};
    trial      = {2'b00, st_i.y, 2'b01};
    take       = rem_sh >= trial;
    diff       = rem_sh - trial;
    st_nxt.rad = {st_i.rad[39:0], 2'b00};
    st_nxt.y   = {st_i.y[19:0], take};
    st_nxt.rem = take ? diff[22:0] : rem_sh[22:0];
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    side_r <= side_i;
  end

  assign st_o   = st_r;
  assign side_o = side_r;

endmodule

/* hdl/sdt_div_cell.sv */
// ----------------------------------------------------------------------------
// sdt_div_cell
// One quotient bit of a restoring divide; the divisor travels with the beat.
// ----------------------------------------------------------------------------
module sdt_div_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  sdt_pkg::dv_st_t      st_i,
  input  logic [SIDE_W-1:0]    side_i,
  output sdt_pkg::dv_st_t      st_o,
  output logic [SIDE_W-1:0]    side_o
);

  sdt_pkg::dv_st_t   st_r, st_nxt;
  logic [SIDE_W-1:0] side_r;
  logic [21:0]       rem_sh, diff;
  logic              take;

  always_comb begin
    // remainder stays below the divisor, so its top bit is always clear
    rem_sh     = {st_i.rem[20:0], st_i.src[21]};
    take       = rem_sh >= {1'b0, st_i.d};
    diff       = rem_sh - {1'b0, st_i.d};
    st_nxt.src = {st_i.src[20:0], 1'b0};
    st_nxt.d   = st_i.d;
    st_nxt.q   = {st_i.q[20:0], take};
    st_nxt.rem = take ? diff : rem_sh;
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    side_r <= side_i;
  end

  assign st_o   = st_r;
  assign side_o = side_r;

endmodule

/* hdl/sdt_horner_cell.sv */
// ----------------------------------------------------------------------------
// sdt_horner_cell
// One Horner step t' = 1 - ((r2*t) >> 30) / d in Q.30, three stages deep.
// ----------------------------------------------------------------------------
module sdt_horner_cell #(
  parameter int SIDE_W = 1
) (
  input  logic                        clk,
  input  logic [sdt_pkg::R2_W-1:0]    r2_i,
  input  logic [sdt_pkg::T_W-1:0]     t_i,
  input  logic [sdt_pkg::DIV_W-1:0]   div_i,
  input  logic [sdt_pkg::RCP_W-1:0]   rcp_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic [sdt_pkg::R2_W-1:0]    r2_o,
  output logic [sdt_pkg::T_W-1:0]     t_o,
  output logic [SIDE_W-1:0]           side_o
);

  logic [60:0]       prod_a;
  logic [62:0]       prod_b;
  logic [37:0]       m_c, rem_c;
  logic              adj_c;
  logic [30:0]       x_a_r, x_b_r, q0_b_r, t_c_r, t_nxt;
  logic [29:0]       r2_a_r, r2_b_r, r2_c_r;
  logic [SIDE_W-1:0] side_a_r, side_b_r, side_c_r;

  assign prod_a = {31'b0, r2_i} * {30'b0, t_i};
  assign prod_b = {32'b0, x_a_r} * {31'b0, rcp_i};

  // reciprocal quotient is at most one short
  always_comb begin
    m_c   = {7'b0, q0_b_r} * {31'b0, div_i};
    rem_c = {7'b0, x_b_r} - m_c;
    adj_c = rem_c >= {31'b0, div_i};
    t_nxt = sdt_pkg::ONE_Q30 - (q0_b_r + {30'b0, adj_c});
  end

  always_ff @(posedge clk) begin
    x_a_r    <= prod_a[60:30];
    r2_a_r   <= r2_i;
    side_a_r <= side_i;
    q0_b_r   <= prod_b[62:32];
    x_b_r    <= x_a_r;
    r2_b_r   <= r2_a_r;
    side_b_r <= side_a_r;
    t_c_r    <= t_nxt;
    r2_c_r   <= r2_b_r;
    side_c_r <= side_b_r;
  end

  assign r2_o   = r2_c_r;
  assign t_o    = t_c_r;
  assign side_o = side_c_r;

endmodule

/* hdl/spontaneous_deformation_tensor_unit.sv */
// ----------------------------------------------------------------------------
// spontaneous_deformation_tensor_unit
// G = n n^T (p - q) + q I from director angle and anisotropy ratio.
// ----------------------------------------------------------------------------
// Channel   Ports                               Beat taken when
// input     in_theta, in_ratio                  start && !busy
// result    out_g_xx, out_g_xy, out_g_yy,       out_valid (one cycle)
//           out_g_zz
//
// One beat per cycle; busy stays low.
// Pipeline: input register (1), cube root (22 cells), square root (21),
// divide (22), angle reduction (3), cosine series (5 cells of 3 stages),
// product/round (4).
// rst_n (synchronous) clears only the valid pipe; in-flight beats are dropped.
// Results cannot be held off; each shows for exactly one cycle.
// ----------------------------------------------------------------------------
module spontaneous_deformation_tensor_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] in_theta,
  input  logic        [15:0] in_ratio,
  output logic               out_valid,
  output logic signed [15:0] out_g_xx,
  output logic signed [15:0] out_g_xy,
  output logic signed [15:0] out_g_yy,
  output logic signed [15:0] out_g_zz
);

  localparam int CB  = sdt_pkg::CB_CELLS;
  localparam int SQ  = sdt_pkg::SQ_CELLS;
  localparam int DV  = sdt_pkg::DV_CELLS;
  localparam int SNC = sdt_pkg::SIN_CELLS;
  localparam int CSC = sdt_pkg::COS_CELLS;
  localparam int LAT = 1 + CB + SQ + DV + 3 + CSC * sdt_pkg::HRN_STAGES + 4;
  localparam int CS_SIDE_W = 47;

  localparam logic signed [34:0] TH0 = sdt_pkg::LIM_Q30;
  localparam logic signed [34:0] TH1 = sdt_pkg::LIM_Q30 + sdt_pkg::HALFPI_Q30;
  localparam logic signed [34:0] TH2 = sdt_pkg::LIM_Q30 + 2 * sdt_pkg::HALFPI_Q30;

  function automatic logic [15:0] rnd_sat(input logic [53:0] mag, input logic neg);
    logic [54:0] sum;
    logic [16:0] m;
    logic [16:0] mn;
    logic [15:0] res;
    sum = {1'b0, mag} + {17'b0, 1'b1, 37'b0};
    m   = sum[54:38];
    mn  = ~m + 17'd1;
    if (neg) begin
      res = (m >= 17'd32768) ? 16'h8000 : mn[15:0];
    end else begin
      res = (m > 17'd32767) ? 16'h7fff : m[15:0];
    end
    return res;
  endfunction

  logic [LAT-1:0] vld_r;
  logic           acc;

  assign busy = 1'b0;
  assign acc  = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], acc};
    end
  end

  // input stage, ratio clamped to 1/16
  logic [15:0] th0_r, a0_r;

  always_ff @(posedge clk) begin
    th0_r <= in_theta;
    a0_r  <= (in_ratio < 16'd256) ? 16'd256 : in_ratio;
  end

  // cube root: P = floor(cbrt(a * 2^48))
  sdt_pkg::cb_st_t cb_st   [0:CB];
  logic [15:0]     cb_side [0:CB];

  assign cb_st[0]   = '{rad: {2'b00, a0_r, 48'b0}, y: '0, y2: '0, rem: '0};
  assign cb_side[0] = th0_r;

  for (genvar i = 0; i < CB; i++) begin : g_cb
    sdt_cbrt_cell #(.SIDE_W(16)) u_cell (
      .clk   (clk),
      .st_i  (cb_st[i]),
      .side_i(cb_side[i]),
      .st_o  (cb_st[i+1]),
      .side_o(cb_side[i+1])
    );
  end

  // square root: S = floor(sqrt(P * 2^20))
  sdt_pkg::sq_st_t sq_st   [0:SQ];
  logic [37:0]     sq_side [0:SQ];

  assign sq_st[0]   = '{rad: {cb_st[CB].y[21:0], 20'b0}, y: '0, rem: '0};
  assign sq_side[0] = {cb_side[CB], cb_st[CB].y};

  for (genvar i = 0; i < SQ; i++) begin : g_sq
    sdt_sqrt_cell #(.SIDE_W(38)) u_cell (
      .clk   (clk),
      .st_i  (sq_st[i]),
      .side_i(sq_side[i]),
      .st_o  (sq_st[i+1]),
      .side_o(sq_side[i+1])
    );
  end

  // divide: Q = floor((2^40 + S/2) / S); top 19 bits of the dividend are below S
  sdt_pkg::dv_st_t dv_st   [0:DV];
  logic [37:0]     dv_side [0:DV];
  logic [40:0]     n_div;

  assign n_div      = {1'b1, 40'b0} + {21'b0, sq_st[SQ].y[20:1]};
  assign dv_st[0]   = '{src: n_div[21:0], d: sq_st[SQ].y, q: '0,
                        rem: {3'b000, n_div[40:22]}};
  assign dv_side[0] = sq_side[SQ];

  for (genvar i = 0; i < DV; i++) begin : g_dv
    sdt_div_cell #(.SIDE_W(38)) u_cell (
      .clk   (clk),
      .st_i  (dv_st[i]),
      .side_i(dv_side[i]),
      .st_o  (dv_st[i+1]),
      .side_o(dv_side[i+1])
    );
  end

  // T1: quadrant count and |P - Q|
  logic [15:0]        th1;
  logic [21:0]        p1, q1;
  logic signed [34:0] r1;
  logic [2:0]         kpos1, kneg1;
  logic signed [2:0]  k1_r;
  logic signed [34:0] r1_r;
  logic [21:0]        q1_r, dmag1_r;
  logic               dneg1_r;

  always_comb begin
    th1   = dv_side[DV][37:22];
    p1    = dv_side[DV][21:0];
    q1    = dv_st[DV].q;
    r1    = {{2{th1[15]}}, th1, 17'b0};
    kpos1 = {2'b0, r1 > TH0} + {2'b0, r1 > TH1} + {2'b0, r1 > TH2};
    kneg1 = {2'b0, r1 < -TH0} + {2'b0, r1 < -TH1} + {2'b0, r1 < -TH2};
  end

  always_ff @(posedge clk) begin
    k1_r    <= kpos1 - kneg1;
    r1_r    <= r1;
    q1_r    <= q1;
    dneg1_r <= p1 < q1;
    dmag1_r <= (p1 < q1) ? (q1 - p1) : (p1 - q1);
  end

  // T2: remove k quarter turns
  logic signed [34:0] kh2, rr2, ra2;
  logic [29:0]        u2_r;
  logic               sneg2_r, kodd2_r, dneg2_r;
  logic [21:0]        q2_r, dmag2_r;

  always_comb begin
    kh2 = k1_r * sdt_pkg::HALFPI_Q30;
    rr2 = r1_r - kh2;
    ra2 = rr2[34] ? -rr2 : rr2;
  end

  always_ff @(posedge clk) begin
    u2_r    <= ra2[29:0];
    sneg2_r <= rr2[34];
    kodd2_r <= k1_r[0];
    q2_r    <= q1_r;
    dneg2_r <= dneg1_r;
    dmag2_r <= dmag1_r;
  end

  // T3: r^2
  logic [59:0]          usq3;
  logic [29:0]          r23_r, u3_r;
  logic [CS_SIDE_W-1:0] cs_side3_r;

  assign usq3 = {30'b0, u2_r} * {30'b0, u2_r};

  always_ff @(posedge clk) begin
    r23_r      <= usq3[59:30];
    u3_r       <= u2_r;
    cs_side3_r <= {sneg2_r, kodd2_r, dneg2_r, dmag2_r, q2_r};
  end

  // cosine and sine series chains
  logic [29:0]          c_r2   [0:CSC];
  logic [30:0]          c_t    [0:CSC];
  logic [CS_SIDE_W-1:0] c_side [0:CSC];
  logic [29:0]          s_r2   [0:SNC];
  logic [30:0]          s_t    [0:SNC];
  logic [29:0]          s_side [0:SNC];

  assign c_r2[0]   = r23_r;
  assign c_t[0]    = sdt_pkg::ONE_Q30;
  assign c_side[0] = cs_side3_r;
  assign s_r2[0]   = r23_r;
  assign s_t[0]    = sdt_pkg::ONE_Q30;
  assign s_side[0] = u3_r;

  for (genvar i = 0; i < CSC; i++) begin : g_cos
    sdt_horner_cell #(.SIDE_W(CS_SIDE_W)) u_cell (
      .clk   (clk),
      .r2_i  (c_r2[i]),
      .t_i   (c_t[i]),
      .div_i (sdt_pkg::COS_DIV[i]),
      .rcp_i (sdt_pkg::COS_RCP[i]),
      .side_i(c_side[i]),
      .r2_o  (c_r2[i+1]),
      .t_o   (c_t[i+1]),
      .side_o(c_side[i+1])
    );
  end

  for (genvar i = 0; i < SNC; i++) begin : g_sin
    sdt_horner_cell #(.SIDE_W(30)) u_cell (
      .clk   (clk),
      .r2_i  (s_r2[i]),
      .t_i   (s_t[i]),
      .div_i (sdt_pkg::SIN_DIV[i]),
      .rcp_i (sdt_pkg::SIN_RCP[i]),
      .side_i(s_side[i]),
      .r2_o  (s_r2[i+1]),
      .t_o   (s_t[i+1]),
      .side_o(s_side[i+1])
    );
  end

  // sine = u * t, then two stages to line up with the longer cosine chain
  logic [60:0] sprod;
  logic [30:0] sf_r, sd1_r, sd2_r;

  assign sprod = {31'b0, s_side[SNC]} * {30'b0, s_t[SNC]};

  always_ff @(posedge clk) begin
    sf_r  <= sprod[60:30];
    sd1_r <= sf_r;
    sd2_r <= sd1_r;
  end

  // F1: squared and cross terms
  logic        sneg_f, kodd_f;
  logic [30:0] ac_f, as_f;
  logic [61:0] c2p, s2p, csp;
  logic [30:0] c2_r, s2_r, cs_r;
  logic        csneg_r, dneg_f1_r;
  logic [21:0] dmag_f1_r, q_f1_r;

  always_comb begin
    sneg_f = c_side[CSC][46];
    kodd_f = c_side[CSC][45];
    ac_f   = kodd_f ? sd2_r : c_t[CSC];
    as_f   = kodd_f ? c_t[CSC] : sd2_r;
    c2p    = {31'b0, ac_f} * {31'b0, ac_f};
    s2p    = {31'b0, as_f} * {31'b0, as_f};
    csp    = {31'b0, ac_f} * {31'b0, as_f};
  end

  always_ff @(posedge clk) begin
    c2_r      <= c2p[60:30];
    s2_r      <= s2p[60:30];
    cs_r      <= csp[60:30];
    csneg_r   <= sneg_f ^ kodd_f;
    dneg_f1_r <= c_side[CSC][44];
    dmag_f1_r <= c_side[CSC][43:22];
    q_f1_r    <= c_side[CSC][21:0];
  end

  // F2: scale by |p - q|
  logic [52:0] tx_r, ty_r, tz_r;
  logic        xyneg_r, dneg_f2_r;
  logic [21:0] q_f2_r;

  always_ff @(posedge clk) begin
    tx_r      <= {22'b0, c2_r} * {31'b0, dmag_f1_r};
    ty_r      <= {22'b0, cs_r} * {31'b0, dmag_f1_r};
    tz_r      <= {22'b0, s2_r} * {31'b0, dmag_f1_r};
    xyneg_r   <= dneg_f1_r ^ csneg_r;
    dneg_f2_r <= dneg_f1_r;
    q_f2_r    <= q_f1_r;
  end

  // F3: add q on the diagonal, split into sign and magnitude
  logic [53:0] base3, vx3, vy3, mx3, my3;
  logic [53:0] mxx_r, myy_r, mxy_r;
  logic        nxx_r, nyy_r, nxy_r;
  logic [21:0] q_f3_r;

  always_comb begin
    base3 = {2'b00, q_f2_r, 30'b0};
    vx3   = dneg_f2_r ? (base3 - {1'b0, tx_r}) : (base3 + {1'b0, tx_r});
    vy3   = dneg_f2_r ? (base3 - {1'b0, tz_r}) : (base3 + {1'b0, tz_r});
    mx3   = vx3[53] ? (~vx3 + 54'd1) : vx3;
    my3   = vy3[53] ? (~vy3 + 54'd1) : vy3;
  end

  always_ff @(posedge clk) begin
    mxx_r  <= mx3;
    nxx_r  <= vx3[53];
    myy_r  <= my3;
    nyy_r  <= vy3[53];
    mxy_r  <= {1'b0, ty_r};
    nxy_r  <= xyneg_r;
    q_f3_r <= q_f2_r;
  end

  // F4: round to Q3.12 and saturate
  logic [22:0] zsum;

  assign zsum = {1'b0, q_f3_r} + 23'd128;

  always_ff @(posedge clk) begin
    out_g_xx <= rnd_sat(mxx_r, nxx_r);
    out_g_xy <= rnd_sat(mxy_r, nxy_r);
    out_g_yy <= rnd_sat(myy_r, nyy_r);
    out_g_zz <= {1'b0, zsum[22:8]};
  end

  assign out_valid = vld_r[LAT-1];

  // every strobe traces back to an accepted beat
  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(acc, LAT))
    else $error("result strobe without matching input beat");

  a_zz_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_g_zz[15])
    else $error("g_zz negative");

  a_zz_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_g_zz != 16'sd0))
    else $error("g_zz zero for a clamped ratio");

endmodule
